// File: src/mei_pkg.sv
// ----------------------------------------------------------------------------
// mei_pkg
// Shared types and constants for the modular exponent / inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package mei_pkg;

  localparam int DATA_W   = 32;
  localparam int BASE_W   = 63;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int EXP_BITS = 32;
  localparam int IDX_W    = $clog2(EXP_BITS);
  localparam int CNT_W    = $clog2(PROD_W);

  localparam logic [DATA_W-1:0] MOD_RESET = 32'd1000000007;

  localparam logic CMD_POWER   = 1'b0;
  localparam logic CMD_INVERSE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BRED,
    ST_BSET,
    ST_SQM,
    ST_SQL,
    ST_SQR,
    ST_SQW,
    ST_MUM,
    ST_MUL,
    ST_MUR,
    ST_MUW,
    ST_NXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic red_step;
    logic red_load;
    logic b_from_rem;
    logic r_from_rem;
    logic mul_sq;
    logic mul_base;
    logic idx_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic red_last;
    logic exp_bit;
    logic idx_zero;
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/mei_ctrl.sv
// ----------------------------------------------------------------------------
// mei_ctrl
// Sequencer for base reduction and left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module mei_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire mei_pkg::dp_status_t status,
  output mei_pkg::dp_cmd_t     cmd,
  output logic                 busy,
  output logic                 done
);
  import mei_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = status.mod_zero ? ST_DONE : ST_BRED;
        end
      end
      ST_BRED: if (status.red_last) state_next = ST_BSET;
      ST_BSET: state_next = ST_SQM;
      ST_SQM:  state_next = ST_SQL;
      ST_SQL:  state_next = ST_SQR;
      ST_SQR:  if (status.red_last) state_next = ST_SQW;
      ST_SQW:  state_next = status.exp_bit ? ST_MUM : ST_NXT;
      ST_MUM:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_MUR;
      ST_MUR:  if (status.red_last) state_next = ST_MUW;
      ST_MUW:  state_next = ST_NXT;
      ST_NXT:  state_next = status.idx_zero ? ST_DONE : ST_SQM;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_BRED:  cmd.red_step   = 1'b1;
      ST_BSET:  cmd.b_from_rem = 1'b1;
      ST_SQM:   cmd.mul_sq     = 1'b1;
      ST_SQL:   cmd.red_load   = 1'b1;
      ST_SQR:   cmd.red_step   = 1'b1;
      ST_SQW:   cmd.r_from_rem = 1'b1;
      ST_MUM:   cmd.mul_base   = 1'b1;
      ST_MUL:   cmd.red_load   = 1'b1;
      ST_MUR:   cmd.red_step   = 1'b1;
      ST_MUW:   cmd.r_from_rem = 1'b1;
      ST_NXT:   cmd.idx_dec    = !status.idx_zero;
      ST_DONE:  done           = 1'b1;
      default:  busy           = 1'b1;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("no return to idle after done");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not start work");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.red_step, cmd.red_load, cmd.b_from_rem,
              cmd.r_from_rem, cmd.mul_sq, cmd.mul_base, cmd.idx_dec}))
    else $error("datapath commands overlap");
`endif

endmodule

`default_nettype wire

// File: src/mei_datapath.sv
// ----------------------------------------------------------------------------
// mei_datapath
// Operand registers, 32x32 multiplier and bit-serial remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mei_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [mei_pkg::DATA_W-1:0]     cfg_wr_data,
  input  wire logic                           command,
  input  wire logic [mei_pkg::BASE_W-1:0]     base,
  input  wire logic [mei_pkg::DATA_W-1:0]     exponent,
  input  wire mei_pkg::dp_cmd_t               cmd,
  output mei_pkg::dp_status_t                 status,
  output logic [mei_pkg::DATA_W-1:0]          result
);
  import mei_pkg::*;

  logic [DATA_W-1:0]   modulus;
  logic [DATA_W-1:0]   b;
  logic [DATA_W-1:0]   r;
  logic [EXP_BITS-1:0] exp_q;
  logic [IDX_W-1:0]    idx;
  logic [PROD_W-1:0]   prod;
  logic [DATA_W-1:0]   rem;
  logic [PROD_W-1:0]   shreg;
  logic [CNT_W-1:0]    cnt;

  logic [DATA_W:0]     trial;
  logic [DATA_W-1:0]   diff;
  logic [DATA_W-1:0]   rem_next;
  logic [DATA_W-1:0]   inv_exp;
  logic [DATA_W-1:0]   mul_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  assign trial    = {rem, shreg[PROD_W-1]};
  assign diff     = trial[DATA_W-1:0] - modulus;
  assign rem_next = (trial >= {1'b0, modulus}) ? diff : trial[DATA_W-1:0];
  assign inv_exp  = (modulus >= DATA_W'(2)) ? modulus - DATA_W'(2) : '0;
  assign mul_op   = cmd.mul_base ? b : r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_q <= EXP_BITS'((command == CMD_INVERSE) ? inv_exp : exponent);
      r     <= (modulus > DATA_W'(1)) ? DATA_W'(1) : '0;
      idx   <= IDX_W'(EXP_BITS - 1);
      rem   <= '0;
      shreg <= {{(PROD_W-BASE_W){1'b0}}, base};
      cnt   <= CNT_W'(PROD_W - 1);
    end else begin
      if (cmd.red_load) begin
        rem   <= prod[PROD_W-1:DATA_W];
        shreg <= {prod[DATA_W-1:0], {DATA_W{1'b0}}};
        cnt   <= CNT_W'(DATA_W - 1);
      end else if (cmd.red_step) begin
        rem   <= rem_next;
        shreg <= {shreg[PROD_W-2:0], 1'b0};
        cnt   <= cnt - CNT_W'(1);
      end
      if (cmd.mul_sq || cmd.mul_base) begin
        prod <= {{DATA_W{1'b0}}, r} * {{DATA_W{1'b0}}, mul_op};
      end
      if (cmd.b_from_rem) b <= rem;
      if (cmd.r_from_rem) r <= rem;
      if (cmd.idx_dec) idx <= idx - IDX_W'(1);
    end
  end

  assign status.mod_zero = (modulus == '0);
  assign status.red_last = (cnt == '0);
  assign status.exp_bit  = exp_q[idx];
  assign status.idx_zero = (idx == '0);
  assign result          = r;

`ifndef NO_ASSERTIONS
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.red_step && modulus != '0 |=> rem < modulus)
    else $error("remainder out of range");

  a_r_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.r_from_rem && modulus != '0 |=> r < modulus)
    else $error("accumulator not reduced");

  a_mod_stable: assert property (@(posedge clk) disable iff (rst)
    cmd.red_step |=> $stable(modulus))
    else $error("modulus changed during reduction");
`endif

endmodule

`default_nettype wire

// File: src/modular_exponent_inverse.sv
// ----------------------------------------------------------------------------
// modular_exponent_inverse
// base^exponent mod modulus, or base^(modulus-2) mod modulus as inverse.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the accepting edge until done. Every
// modular product goes through a one-bit-per-cycle remainder unit (32 steps;
// 64 for the initial base reduction). With a zero modulus the result is 0 and
// the block goes from idle straight to done. The result is on result for the
// one cycle that done is high and must be taken then; there is no stall.
`default_nettype none

module modular_exponent_inverse (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [mei_pkg::DATA_W-1:0]  cfg_wr_data,
  input  wire logic                        start,
  input  wire logic                        command,
  input  wire logic [mei_pkg::BASE_W-1:0]  base,
  input  wire logic [mei_pkg::DATA_W-1:0]  exponent,
  output logic                             busy,
  output logic                             done,
  output logic [mei_pkg::DATA_W-1:0]       result
);
  import mei_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mei_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mei_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .command     (command),
    .base        (base),
    .exponent    (exponent),
    .cmd         (cmd),
    .status      (status),
    .result      (result)
  );

endmodule

`default_nettype wire
